### src/alp_pkg.sv
// Shared types and constants for the augmented Lagrangian penalty unit.
// Used by the configuration block, the controller, the datapath and the top level.
package alp_pkg;

    // Turn-rate terms take part in both violation sums when set
    localparam logic USE_TURN = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LIM_W      = 23;
    localparam int CTRL_W     = 24;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_SPEED_LIMIT       = 3'd0,
        IDX_TURN_RATE_LIMIT   = 3'd1,
        IDX_ACCEL_LIMIT_SPEED = 3'd2,
        IDX_ACCEL_LIMIT_TURN  = 3'd3,
        IDX_INV_STEP_TIME     = 3'd4,
        IDX_PENALTY_GROWTH    = 3'd5,
        IDX_PENALTY_MAX       = 3'd6,
        IDX_PENALTY_INIT      = 3'd7
    } cfg_idx_t;

    localparam logic [LIM_W-1:0] SPEED_LIMIT_RST       = 23'd65536;
    localparam logic [LIM_W-1:0] TURN_RATE_LIMIT_RST   = 23'd65536;
    localparam logic [LIM_W-1:0] ACCEL_LIMIT_SPEED_RST = 23'd65536;
    localparam logic [LIM_W-1:0] ACCEL_LIMIT_TURN_RST  = 23'd65536;
    localparam logic [LIM_W-1:0] INV_STEP_TIME_RST     = 23'd655360;
    localparam logic [LIM_W-1:0] PENALTY_GROWTH_RST    = 23'd98304;
    localparam logic [31:0]      PENALTY_MAX_RST       = 32'd65536000;
    localparam logic [31:0]      PENALTY_INIT_RST      = 32'd65536;

    typedef struct packed {
        logic [LIM_W-1:0] speed_limit;
        logic [LIM_W-1:0] turn_rate_limit;
        logic [LIM_W-1:0] accel_limit_speed;
        logic [LIM_W-1:0] accel_limit_turn;
        logic [LIM_W-1:0] inv_step_time;
        logic [LIM_W-1:0] penalty_growth;
        logic [31:0]      penalty_max;
        logic [31:0]      penalty_init;
        logic             init_load;     // set in the cycle after a penalty_init write
    } cfg_t;

    // Operand pair for the shared 32x32 multiplier
    typedef enum logic [3:0] {
        MUL_DSPD,
        MUL_DTRN,
        MUL_LV_GV,
        MUL_LA_GA,
        MUL_GV_GV,
        MUL_GA_GA,
        MUL_SQLO_MU,
        MUL_SQHI_MU,
        MUL_MU_GV,
        MUL_MU_GA,
        MUL_MU_GROW
    } mul_sel_t;

    // Accumulate step, consumes the registered product issued in the previous cycle
    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_VEL_SPD,
        ACC_VT_AS,
        ACC_AT,
        ACC_LAG0,
        ACC_LAG1,
        ACC_SQ0,
        ACC_SQ1,
        ACC_PLO,
        ACC_PEN,
        ACC_COST,
        ACC_MV,
        ACC_MA,
        ACC_MU
    } acc_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VS,
        ST_VT,
        ST_AT,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8,
        ST_D0, ST_D1, ST_D2, ST_D3,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last_step;
        logic cmd;
        logic out_busy;
    } dp_status_t;

endpackage

### src/augmented_lagrangian_penalty_unit.sv
// Top level of the augmented Lagrangian constraint penalty unit.
// Instantiates alp_cfg, alp_ctrl and alp_datapath; depends on alp_pkg.

// Takes one control timestep per request (speed, turn rate, Q8.16) and keeps
// velocity and acceleration violation sums over a sequence. The next request
// is accepted only once the sequencer is back in idle: after the rate-of-change
// steps, and on the last step also after the scored sample (tuser 0) or the
// dual update (tuser 1) and any wait for the previous result to be taken. The
// sequencer runs every product (rate of change, Lagrangian, squared sums,
// penalty, mu growth) through one shared 32x32 multiplier with a registered
// product. A result sits in an output register, so the next request is
// accepted while it waits. Writing penalty_init also reloads mu and clears
// both multipliers. No clearing pass follows reset.
module augmented_lagrangian_penalty_unit import alp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // control_speed [23:0], control_turn [47:24], base_cost [79:48]
    input  logic [79:0]           s_tdata,
    input  logic                  s_tlast,    // last_step
    input  logic                  s_tuser,    // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // augmented_cost [47:0], total_violation [79:48], penalty_weight [111:80],
    // violated count [113:112], zero fill [119:114]
    output logic [119:0]          m_tdata,
    output logic                  m_tuser     // result_kind
);

    cfg_t       cfg;
    dp_cmd_t    dp_cmd;
    dp_status_t status;

    alp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    alp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .dp_cmd   (dp_cmd)
    );

    alp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .dp_cmd   (dp_cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### src/alp_cfg.sv
// Configuration register file of the penalty unit.
// Depends on alp_pkg for the register indexes, reset values and cfg_t.
module alp_cfg import alp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next           = cfg_reg;
        cfg_next.init_load = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                IDX_SPEED_LIMIT:       cfg_next.speed_limit       = cfg_wdata[LIM_W-1:0];
                IDX_TURN_RATE_LIMIT:   cfg_next.turn_rate_limit   = cfg_wdata[LIM_W-1:0];
                IDX_ACCEL_LIMIT_SPEED: cfg_next.accel_limit_speed = cfg_wdata[LIM_W-1:0];
                IDX_ACCEL_LIMIT_TURN:  cfg_next.accel_limit_turn  = cfg_wdata[LIM_W-1:0];
                IDX_INV_STEP_TIME:     cfg_next.inv_step_time     = cfg_wdata[LIM_W-1:0];
                IDX_PENALTY_GROWTH:    cfg_next.penalty_growth    = cfg_wdata[LIM_W-1:0];
                IDX_PENALTY_MAX:       cfg_next.penalty_max       = cfg_wdata;
                IDX_PENALTY_INIT: begin
                    cfg_next.penalty_init = cfg_wdata;
                    cfg_next.init_load    = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_limit       <= SPEED_LIMIT_RST;
            cfg_reg.turn_rate_limit   <= TURN_RATE_LIMIT_RST;
            cfg_reg.accel_limit_speed <= ACCEL_LIMIT_SPEED_RST;
            cfg_reg.accel_limit_turn  <= ACCEL_LIMIT_TURN_RST;
            cfg_reg.inv_step_time     <= INV_STEP_TIME_RST;
            cfg_reg.penalty_growth    <= PENALTY_GROWTH_RST;
            cfg_reg.penalty_max       <= PENALTY_MAX_RST;
            cfg_reg.penalty_init      <= PENALTY_INIT_RST;
            cfg_reg.init_load         <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/alp_ctrl.sv
// Sequencer of the penalty unit: steps the shared multiplier and accumulator.
// Depends on alp_pkg for state_t, dp_cmd_t and dp_status_t.
module alp_ctrl import alp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        dp_cmd.load_in = 1'b0;
        dp_cmd.mul_sel = MUL_DSPD;
        dp_cmd.acc_op  = ACC_NONE;
        dp_cmd.emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    dp_cmd.load_in = 1'b1;
                    state_next     = ST_VS;
                end
            end
            ST_VS: begin
                dp_cmd.mul_sel = MUL_DSPD;
                dp_cmd.acc_op  = ACC_VEL_SPD;
                state_next     = ST_VT;
            end
            ST_VT: begin
                dp_cmd.mul_sel = MUL_DTRN;
                dp_cmd.acc_op  = ACC_VT_AS;
                state_next     = ST_AT;
            end
            ST_AT: begin
                dp_cmd.acc_op = ACC_AT;
                if (!status.last_step) begin
                    state_next = ST_IDLE;
                end else if (status.cmd) begin
                    state_next = ST_D0;
                end else begin
                    state_next = ST_F0;
                end
            end
            // scored sample: Lagrangian, squared sums, penalty, cost
            ST_F0: begin
                dp_cmd.mul_sel = MUL_LV_GV;
                state_next     = ST_F1;
            end
            ST_F1: begin
                dp_cmd.mul_sel = MUL_LA_GA;
                dp_cmd.acc_op  = ACC_LAG0;
                state_next     = ST_F2;
            end
            ST_F2: begin
                dp_cmd.mul_sel = MUL_GV_GV;
                dp_cmd.acc_op  = ACC_LAG1;
                state_next     = ST_F3;
            end
            ST_F3: begin
                dp_cmd.mul_sel = MUL_GA_GA;
                dp_cmd.acc_op  = ACC_SQ0;
                state_next     = ST_F4;
            end
            ST_F4: begin
                dp_cmd.acc_op = ACC_SQ1;
                state_next    = ST_F5;
            end
            ST_F5: begin
                dp_cmd.mul_sel = MUL_SQLO_MU;
                state_next     = ST_F6;
            end
            ST_F6: begin
                dp_cmd.mul_sel = MUL_SQHI_MU;
                dp_cmd.acc_op  = ACC_PLO;
                state_next     = ST_F7;
            end
            ST_F7: begin
                dp_cmd.acc_op = ACC_PEN;
                state_next    = ST_F8;
            end
            ST_F8: begin
                dp_cmd.acc_op = ACC_COST;
                state_next    = ST_OUT;
            end
            // dual update: multipliers first, mu last so both see the old mu
            ST_D0: begin
                dp_cmd.mul_sel = MUL_MU_GV;
                state_next     = ST_D1;
            end
            ST_D1: begin
                dp_cmd.mul_sel = MUL_MU_GA;
                dp_cmd.acc_op  = ACC_MV;
                state_next     = ST_D2;
            end
            ST_D2: begin
                dp_cmd.mul_sel = MUL_MU_GROW;
                dp_cmd.acc_op  = ACC_MA;
                state_next     = ST_D3;
            end
            ST_D3: begin
                dp_cmd.acc_op = ACC_MU;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    dp_cmd.emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_VS))
        else $error("accepted request did not start the step sequence");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit |-> !status.out_busy)
        else $error("result emitted over a pending result");

    a_non_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AT && !status.last_step) |=> (state_reg == ST_IDLE))
        else $error("non-last step did not return to idle");

endmodule

### src/alp_datapath.sv
// Datapath of the penalty unit: violation sums, multipliers, mu, one shared
// 32x32 multiplier and the output register. Depends on alp_pkg.
module alp_datapath import alp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  dp_cmd_t       dp_cmd,
    output dp_status_t    status,
    input  logic [79:0]   s_tdata,
    input  logic          s_tuser,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [119:0]  m_tdata,
    output logic          m_tuser
);

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic logic [31:0] excess32(input logic [31:0] v, input logic [LIM_W-1:0] lim);
        logic [31:0] l;
        l = {{(32-LIM_W){1'b0}}, lim};
        return (v > l) ? (v - l) : 32'd0;
    endfunction

    // (p >> 16) saturated to 32 bits
    function automatic logic [31:0] shr16_sat32(input logic [63:0] p);
        return (|p[63:48]) ? 32'hFFFF_FFFF : p[47:16];
    endfunction

    // input item
    logic signed [CTRL_W-1:0] sp_reg, tr_reg;
    logic [31:0]              base_reg;
    logic                     cmd_reg, last_reg;

    // per-sequence and persistent state
    logic signed [CTRL_W-1:0] prev_speed_reg, prev_speed_next;
    logic signed [CTRL_W-1:0] prev_turn_reg, prev_turn_next;
    logic                     first_reg, first_next;
    logic [31:0]              vel_sum_reg, vel_sum_next;
    logic [31:0]              acc_sum_reg, acc_sum_next;
    logic [31:0]              mv_reg, mv_next;
    logic [31:0]              ma_reg, ma_next;
    logic [31:0]              mu_reg, mu_next;

    // scratch for the sequence end
    logic [63:0] p_reg, p_next;
    logic [47:0] lag_reg, lag_next;
    logic [47:0] sq_reg, sq_next;
    logic [63:0] plo_reg, plo_next;
    logic [47:0] pen_reg, pen_next;
    logic [47:0] cost_reg, cost_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic        out_kind_reg;
    logic [47:0] out_cost_reg;
    logic [31:0] out_total_reg;
    logic [31:0] out_mu_reg;
    logic [1:0]  out_nv_reg;

    logic [CTRL_W-1:0] abs_sp, abs_tr;
    logic [CTRL_W:0]   d_sp, d_tr, ad_sp, ad_tr;
    logic [31:0]       mul_a, mul_b;
    logic [79:0]       pen_full;
    logic [31:0]       total;
    logic [1:0]        nv;
    logic [31:0]       mu_grown;

    assign abs_sp = sp_reg[CTRL_W-1] ? (~sp_reg + 1'b1) : sp_reg;
    assign abs_tr = tr_reg[CTRL_W-1] ? (~tr_reg + 1'b1) : tr_reg;
    assign d_sp   = {sp_reg[CTRL_W-1], sp_reg} - {prev_speed_reg[CTRL_W-1], prev_speed_reg};
    assign d_tr   = {tr_reg[CTRL_W-1], tr_reg} - {prev_turn_reg[CTRL_W-1], prev_turn_reg};
    assign ad_sp  = d_sp[CTRL_W] ? (~d_sp + 1'b1) : d_sp;
    assign ad_tr  = d_tr[CTRL_W] ? (~d_tr + 1'b1) : d_tr;

    assign total    = sat_add32(vel_sum_reg, acc_sum_reg);
    assign nv       = {1'b0, vel_sum_reg != 32'd0} + {1'b0, acc_sum_reg != 32'd0};
    assign pen_full = {16'd0, plo_reg} + {p_reg[47:0], 32'd0};
    assign mu_grown = shr16_sat32(p_reg);

    always_comb begin
        unique case (dp_cmd.mul_sel)
            MUL_DSPD: begin
                mul_a = {{(31-CTRL_W){1'b0}}, ad_sp};
                mul_b = {{(32-LIM_W){1'b0}}, cfg.inv_step_time};
            end
            MUL_DTRN: begin
                mul_a = {{(31-CTRL_W){1'b0}}, ad_tr};
                mul_b = {{(32-LIM_W){1'b0}}, cfg.inv_step_time};
            end
            MUL_LV_GV: begin
                mul_a = mv_reg;
                mul_b = vel_sum_reg;
            end
            MUL_LA_GA: begin
                mul_a = ma_reg;
                mul_b = acc_sum_reg;
            end
            MUL_GV_GV: begin
                mul_a = vel_sum_reg;
                mul_b = vel_sum_reg;
            end
            MUL_GA_GA: begin
                mul_a = acc_sum_reg;
                mul_b = acc_sum_reg;
            end
            MUL_SQLO_MU: begin
                mul_a = sq_reg[31:0];
                mul_b = mu_reg;
            end
            MUL_SQHI_MU: begin
                mul_a = {16'd0, sq_reg[47:32]};
                mul_b = mu_reg;
            end
            MUL_MU_GV: begin
                mul_a = mu_reg;
                mul_b = vel_sum_reg;
            end
            MUL_MU_GA: begin
                mul_a = mu_reg;
                mul_b = acc_sum_reg;
            end
            MUL_MU_GROW: begin
                mul_a = mu_reg;
                mul_b = {{(32-LIM_W){1'b0}}, cfg.penalty_growth};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign p_next = mul_a * mul_b;

    always_comb begin
        prev_speed_next = prev_speed_reg;
        prev_turn_next  = prev_turn_reg;
        first_next      = first_reg;
        vel_sum_next    = vel_sum_reg;
        acc_sum_next    = acc_sum_reg;
        mv_next         = mv_reg;
        ma_next         = ma_reg;
        mu_next         = mu_reg;
        lag_next        = lag_reg;
        sq_next         = sq_reg;
        plo_next        = plo_reg;
        pen_next        = pen_reg;
        cost_next       = cost_reg;
        unique case (dp_cmd.acc_op)
            ACC_NONE: ;
            ACC_VEL_SPD: begin
                vel_sum_next = sat_add32(vel_sum_reg,
                    excess32({{(32-CTRL_W){1'b0}}, abs_sp}, cfg.speed_limit));
            end
            ACC_VT_AS: begin
                if (USE_TURN) begin
                    vel_sum_next = sat_add32(vel_sum_reg,
                        excess32({{(32-CTRL_W){1'b0}}, abs_tr}, cfg.turn_rate_limit));
                end
                if (!first_reg) begin
                    acc_sum_next = sat_add32(acc_sum_reg,
                        excess32(p_reg[47:16], cfg.accel_limit_speed));
                end
            end
            ACC_AT: begin
                if (USE_TURN && !first_reg) begin
                    acc_sum_next = sat_add32(acc_sum_reg,
                        excess32(p_reg[47:16], cfg.accel_limit_turn));
                end
                prev_speed_next = sp_reg;
                prev_turn_next  = tr_reg;
                first_next      = 1'b0;
            end
            ACC_LAG0: lag_next = p_reg[63:16];
            ACC_LAG1: lag_next = sat_add48(lag_reg, p_reg[63:16]);
            ACC_SQ0:  sq_next  = p_reg[63:16];
            ACC_SQ1:  sq_next  = sat_add48(sq_reg, p_reg[63:16]);
            ACC_PLO: begin
                plo_next = p_reg;
                lag_next = sat_add48({16'd0, base_reg}, lag_reg);
            end
            ACC_PEN: begin
                // (sq * mu) >> 17, product assembled from two 32-bit halves
                pen_next = (|pen_full[79:65]) ? 48'hFFFF_FFFF_FFFF : pen_full[64:17];
            end
            ACC_COST: cost_next = sat_add48(lag_reg, pen_reg);
            ACC_MV:   mv_next   = sat_add32(mv_reg, shr16_sat32(p_reg));
            ACC_MA:   ma_next   = sat_add32(ma_reg, shr16_sat32(p_reg));
            ACC_MU: begin
                if (nv != 2'd0) begin
                    mu_next = (mu_grown < cfg.penalty_max) ? mu_grown : cfg.penalty_max;
                end
            end
            default: ;
        endcase
        if (cfg.init_load) begin
            mu_next = cfg.penalty_init;
            mv_next = 32'd0;
            ma_next = 32'd0;
        end
        if (dp_cmd.emit) begin
            vel_sum_next = 32'd0;
            acc_sum_next = 32'd0;
            first_next   = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (dp_cmd.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_speed_reg <= '0;
            prev_turn_reg  <= '0;
            first_reg      <= 1'b1;
            vel_sum_reg    <= 32'd0;
            acc_sum_reg    <= 32'd0;
            mv_reg         <= 32'd0;
            ma_reg         <= 32'd0;
            mu_reg         <= PENALTY_INIT_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            prev_speed_reg <= prev_speed_next;
            prev_turn_reg  <= prev_turn_next;
            first_reg      <= first_next;
            vel_sum_reg    <= vel_sum_next;
            acc_sum_reg    <= acc_sum_next;
            mv_reg         <= mv_next;
            ma_reg         <= ma_next;
            mu_reg         <= mu_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg    <= p_next;
        lag_reg  <= lag_next;
        sq_reg   <= sq_next;
        plo_reg  <= plo_next;
        pen_reg  <= pen_next;
        cost_reg <= cost_next;
        if (dp_cmd.load_in) begin
            sp_reg   <= s_tdata[23:0];
            tr_reg   <= s_tdata[47:24];
            base_reg <= s_tdata[79:48];
            cmd_reg  <= s_tuser;
            last_reg <= s_tlast;
        end
        if (dp_cmd.emit) begin
            out_kind_reg  <= cmd_reg;
            out_cost_reg  <= cmd_reg ? 48'd0 : cost_reg;
            out_total_reg <= total;
            out_mu_reg    <= mu_reg;
            out_nv_reg    <= nv;
        end
    end

    assign status.last_step = last_reg;
    assign status.cmd       = cmd_reg;
    assign status.out_busy  = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_nv_reg, out_mu_reg, out_total_reg, out_cost_reg};

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for augmented_lagrangian_penalty_unit: streams control steps,
// predicts each cost or dual-update result in-line and checks them in order.
// Depends on alp_pkg and the RTL under src/.
module testbench;
    import alp_pkg::*;

    localparam logic CMD_SCORE = 1'b0;
    localparam logic CMD_DUAL  = 1'b1;

    localparam logic [63:0] CAP32 = 64'hFFFF_FFFF;
    localparam logic [63:0] CAP48 = 64'hFFFF_FFFF_FFFF;
    localparam int          FRAC_BITS = 16;
    localparam int          HALF_FRAC_BITS = 17;   // Q16 product plus the mu/2 factor

    localparam logic [22:0] LIM_MAX = 23'h7F_FFFF;
    localparam logic [23:0] CTRL_POS_MAX = 24'h7F_FFFF;
    localparam logic [23:0] CTRL_NEG_MAX = 24'h80_0000;

    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 200;

    typedef struct packed {
        logic        kind;
        logic [47:0] cost;
        logic [31:0] total;
        logic [31:0] mu;
        logic [1:0]  nviol;
    } penalty_result_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [119:0]          m_tdata;
    logic                  m_tuser;

    augmented_lagrangian_penalty_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Predicted configuration and sequence state
    logic [22:0] lim_speed      = SPEED_LIMIT_RST;
    logic [22:0] lim_turn       = TURN_RATE_LIMIT_RST;
    logic [22:0] lim_acc_speed  = ACCEL_LIMIT_SPEED_RST;
    logic [22:0] lim_acc_turn   = ACCEL_LIMIT_TURN_RST;
    logic [22:0] inv_dt         = INV_STEP_TIME_RST;
    logic [22:0] grow_factor    = PENALTY_GROWTH_RST;
    logic [31:0] mu_cap         = PENALTY_MAX_RST;
    logic [31:0] mu             = PENALTY_INIT_RST;
    logic [31:0] lambda_vel     = '0;
    logic [31:0] lambda_acc     = '0;
    logic [31:0] vel_sum        = '0;
    logic [31:0] acc_sum        = '0;
    longint      prev_spd       = 0;
    longint      prev_trn       = 0;
    bit          seq_start      = 1'b1;

    penalty_result_t pending_penalty_results[$];
    int unsigned     error_count = 0;
    int unsigned     cycle_count = 0;

    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned hold_count = 0;
    int unsigned rx_gap_left = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count++;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL augmented_lagrangian_penalty_unit");
        $finish;
    end

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
        logic [64:0] s;
        s = a + b;
        return (s > cap) ? cap : s[63:0];
    endfunction

    function automatic logic [63:0] over_limit(logic [63:0] v, logic [63:0] lim);
        return (v > lim) ? v - lim : 64'd0;
    endfunction

    function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b, int sh,
                                                  logic [63:0] cap);
        logic [127:0] p;
        p = a * b;
        p = p >> sh;
        return (p > cap) ? cap : p[63:0];
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the predicted state by one accepted step; returns 1 when a result is due
    function automatic bit predict_penalty_step(logic cmd, logic [23:0] spd_raw,
                                                logic [23:0] trn_raw, logic [31:0] base,
                                                logic last, output penalty_result_t res);
        longint      spd, trn;
        logic [63:0] rate, gv, ga, lag, sq, pen, cost, grown;
        logic [1:0]  nv;
        spd = longint'(signed'(spd_raw));
        trn = longint'(signed'(trn_raw));
        res = '0;
        vel_sum = 32'(sat_add(vel_sum, over_limit(magnitude(spd), lim_speed), CAP32));
        if (USE_TURN)
            vel_sum = 32'(sat_add(vel_sum, over_limit(magnitude(trn), lim_turn), CAP32));
        if (!seq_start) begin
            rate = (64'(magnitude(spd - prev_spd)) * inv_dt) >> FRAC_BITS;
            acc_sum = 32'(sat_add(acc_sum, over_limit(rate, lim_acc_speed), CAP32));
            if (USE_TURN) begin
                rate = (64'(magnitude(trn - prev_trn)) * inv_dt) >> FRAC_BITS;
                acc_sum = 32'(sat_add(acc_sum, over_limit(rate, lim_acc_turn), CAP32));
            end
        end
        prev_spd = spd;
        prev_trn = trn;
        seq_start = 1'b0;
        if (!last) return 1'b0;

        gv = 64'(vel_sum);
        ga = 64'(acc_sum);
        nv = 2'(gv != 0) + 2'(ga != 0);
        cost = '0;
        if (cmd == CMD_SCORE) begin
            lag = sat_add(mul_shift_sat(lambda_vel, gv, FRAC_BITS, CAP48),
                          mul_shift_sat(lambda_acc, ga, FRAC_BITS, CAP48), CAP48);
            sq = sat_add(mul_shift_sat(gv, gv, FRAC_BITS, CAP48),
                         mul_shift_sat(ga, ga, FRAC_BITS, CAP48), CAP48);
            pen = mul_shift_sat(sq, mu, HALF_FRAC_BITS, CAP48);
            cost = sat_add(sat_add(base, lag, CAP48), pen, CAP48);
        end else begin
            // multipliers move with the old mu, then mu grows
            lambda_vel = 32'(sat_add(lambda_vel, mul_shift_sat(mu, gv, FRAC_BITS, CAP32),
                                     CAP32));
            lambda_acc = 32'(sat_add(lambda_acc, mul_shift_sat(mu, ga, FRAC_BITS, CAP32),
                                     CAP32));
            if (nv != 0) begin
                grown = mul_shift_sat(mu, grow_factor, FRAC_BITS, CAP32);
                mu = (grown < mu_cap) ? grown[31:0] : mu_cap;
            end
        end
        res.kind  = cmd;
        res.cost  = cost[47:0];
        res.total = 32'(sat_add(gv, ga, CAP32));
        res.mu    = mu;
        res.nviol = nv;
        vel_sum = '0;
        acc_sum = '0;
        seq_start = 1'b1;
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off counted here
    always @(posedge aclk) begin
        if (long_hold_req && hold_count < LONG_HOLD) begin
            m_tready <= 1'b0;
            hold_count++;
        end else begin
            if (!long_hold_req) hold_count = 0;
            if (rx_gap_left != 0) begin
                m_tready <= 1'b0;
                rx_gap_left--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle_en) rx_gap_left = pick_gap();
            end
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        penalty_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_penalty_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %0h kind %0b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                exp_r = pending_penalty_results.pop_front();
                check_field("result_kind", exp_r.kind, m_tuser);
                check_field("augmented_cost", exp_r.cost, m_tdata[47:0]);
                check_field("total_violation", exp_r.total, m_tdata[79:48]);
                check_field("penalty_weight", exp_r.mu, m_tdata[111:80]);
                check_field("violated_count", exp_r.nviol, m_tdata[113:112]);
            end
        end
    end

    // Offer one step and hold it until the block takes it
    task automatic send_control_step(logic cmd, logic [23:0] spd, logic [23:0] trn,
                                     logic [31:0] base, logic last);
        int unsigned     gap;
        penalty_result_t res;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {base, trn, spd};
        s_tlast  <= last;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        if (predict_penalty_step(cmd, spd, trn, base, last, res))
            pending_penalty_results.push_back(res);
    endtask

    // Drop valid and let every outstanding result and in-flight step finish
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_penalty_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            IDX_SPEED_LIMIT:       lim_speed     = value[22:0];
            IDX_TURN_RATE_LIMIT:   lim_turn      = value[22:0];
            IDX_ACCEL_LIMIT_SPEED: lim_acc_speed = value[22:0];
            IDX_ACCEL_LIMIT_TURN:  lim_acc_turn  = value[22:0];
            IDX_INV_STEP_TIME:     inv_dt        = value[22:0];
            IDX_PENALTY_GROWTH:    grow_factor   = value[22:0];
            IDX_PENALTY_MAX:       mu_cap        = value;
            IDX_PENALTY_INIT: begin
                mu = value;
                lambda_vel = '0;
                lambda_acc = '0;
            end
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_limits(logic [22:0] v, logic [22:0] inv);
        write_reg(IDX_SPEED_LIMIT, 32'(v));
        write_reg(IDX_TURN_RATE_LIMIT, 32'(v));
        write_reg(IDX_ACCEL_LIMIT_SPEED, 32'(v));
        write_reg(IDX_ACCEL_LIMIT_TURN, 32'(v));
        write_reg(IDX_INV_STEP_TIME, 32'(inv));
    endtask

    task automatic test_reset_defaults();
        send_control_step(CMD_SCORE, 24'd0, 24'd0, 32'd0, 1'b1);
        send_control_step(CMD_SCORE, CTRL_NEG_MAX, CTRL_POS_MAX, 32'hFFFF_FFFF, 1'b1);
        // full-scale swing between steps drives both rate terms
        send_control_step(CMD_DUAL, CTRL_POS_MAX, CTRL_NEG_MAX, 32'h1234_5678, 1'b0);
        send_control_step(CMD_DUAL, CTRL_NEG_MAX, CTRL_POS_MAX, 32'd0, 1'b1);
        // cmd and base are ignored before the last step
        send_control_step(CMD_DUAL, 24'h00_8000, 24'hFF_8000, 32'hDEAD_BEEF, 1'b0);
        send_control_step(CMD_DUAL, 24'h00_C000, 24'hFF_0000, 32'd0, 1'b0);
        send_control_step(CMD_SCORE, 24'h00_C000, 24'hFF_0000, 32'd12345, 1'b1);
        // clean dual update leaves mu alone
        send_control_step(CMD_DUAL, 24'd0, 24'd0, 32'd0, 1'b1);
        send_control_step(CMD_SCORE, 24'h01_8000, 24'd0, 32'h100, 1'b1);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_limits(LIM_MAX, 23'd0);
        write_reg(IDX_PENALTY_GROWTH, 32'(LIM_MAX));
        write_reg(IDX_PENALTY_MAX, 32'hFFFF_FFFF);
        write_reg(IDX_PENALTY_INIT, 32'hFFFF_FFFF);
        send_control_step(CMD_SCORE, CTRL_NEG_MAX, CTRL_NEG_MAX, 32'hFFFF_FFFF, 1'b0);
        send_control_step(CMD_SCORE, CTRL_POS_MAX, CTRL_POS_MAX, 32'hFFFF_FFFF, 1'b1);
        send_control_step(CMD_DUAL, CTRL_NEG_MAX, CTRL_NEG_MAX, 32'd0, 1'b1);
        wait_drained();
        write_limits(23'd0, LIM_MAX);
        write_reg(IDX_PENALTY_GROWTH, 32'd0);
        write_reg(IDX_PENALTY_MAX, 32'd0);
        write_reg(IDX_PENALTY_INIT, 32'd0);
        send_control_step(CMD_DUAL, 24'd1, 24'hFF_FFFF, 32'd0, 1'b0);
        send_control_step(CMD_DUAL, 24'd0, 24'd0, 32'd0, 1'b1);
        send_control_step(CMD_SCORE, 24'd1, 24'd0, 32'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_penalty_ramp();
        write_limits(23'h1_0000, 23'h1_0000);
        write_reg(IDX_PENALTY_GROWTH, 32'(LIM_MAX));
        write_reg(IDX_PENALTY_MAX, 32'hFFFF_FFFF);
        write_reg(IDX_PENALTY_INIT, 32'h1_0000);
        repeat (4) send_control_step(CMD_DUAL, CTRL_POS_MAX, 24'd0, 32'd0, 1'b1);
        wait_drained();
        write_reg(IDX_PENALTY_MAX, 32'h0100_0000);
        send_control_step(CMD_DUAL, 24'h02_0000, 24'd0, 32'd0, 1'b1);
        wait_drained();
        // reloading mu also clears the multipliers
        write_reg(IDX_PENALTY_INIT, 32'h8000);
        send_control_step(CMD_SCORE, 24'h03_0000, 24'hFD_0000, 32'd77, 1'b1);
        wait_drained();
    endtask

    // Long full-scale runs so both violation sums and the cost hit saturation
    task automatic test_saturation();
        int i;
        write_limits(23'd0, LIM_MAX);
        write_reg(IDX_PENALTY_GROWTH, 32'h1_8000);
        write_reg(IDX_PENALTY_MAX, 32'hFFFF_FFFF);
        write_reg(IDX_PENALTY_INIT, 32'h10_0000);
        for (i = 0; i < 520; i++)
            send_control_step((i >= 260) ? CMD_DUAL : CMD_SCORE,
                              i[0] ? CTRL_NEG_MAX : CTRL_POS_MAX,
                              i[0] ? CTRL_POS_MAX : CTRL_NEG_MAX,
                              $urandom(), (i == 259) || (i == 519));
        send_control_step(CMD_SCORE, CTRL_POS_MAX, CTRL_POS_MAX, 32'hFFFF_FFFF, 1'b1);
        wait_drained();
    endtask

    // Hold the result side off while the sender keeps offering finished sequences
    task automatic test_backpressure();
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        long_hold_req = 1'b1;
        repeat (12) send_control_step(1'($urandom_range(0, 1)), 24'($urandom()),
                                      24'($urandom()), $urandom(), 1'b1);
        while (hold_count < LONG_HOLD) @(posedge aclk);
        long_hold_req = 1'b0;
        wait_drained();
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
    endtask

    function automatic logic [22:0] rand_limit();
        case ($urandom_range(0, 9))
            0: return 23'd0;
            1: return LIM_MAX;
            default: return 23'($urandom_range(16384, 3 * 65536));
        endcase
    endfunction

    function automatic logic [23:0] rand_ctrl(logic [22:0] lim);
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 24'($urandom());
            4, 5, 6:    v = 24'(lim) + 24'($urandom_range(0, 512)) - 24'd256;
            7:          v = $urandom_range(0, 1) ? CTRL_POS_MAX : CTRL_NEG_MAX;
            default:    v = 24'($urandom_range(0, 2 * 65536));
        endcase
        if (v != CTRL_NEG_MAX && $urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic logic [31:0] rand_base();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic write_random_config();
        logic [31:0] v;
        write_reg(IDX_SPEED_LIMIT, 32'(rand_limit()));
        write_reg(IDX_TURN_RATE_LIMIT, 32'(rand_limit()));
        write_reg(IDX_ACCEL_LIMIT_SPEED, 32'(rand_limit()));
        write_reg(IDX_ACCEL_LIMIT_TURN, 32'(rand_limit()));
        case ($urandom_range(0, 9))
            0:       v = 32'd0;
            1:       v = 32'(LIM_MAX);
            default: v = $urandom_range(65536, 20 * 65536);
        endcase
        write_reg(IDX_INV_STEP_TIME, v);
        case ($urandom_range(0, 9))
            0:       v = 32'd0;
            1:       v = 32'(LIM_MAX);
            2:       v = 32'h1_0000;
            default: v = $urandom_range(65536, 3 * 65536);
        endcase
        write_reg(IDX_PENALTY_GROWTH, v);
        case ($urandom_range(0, 9))
            0:       v = 32'd0;
            1:       v = 32'hFFFF_FFFF;
            default: v = $urandom_range(65536, 200 * 65536);
        endcase
        write_reg(IDX_PENALTY_MAX, v);
        if ($urandom_range(0, 1))
            write_reg(IDX_PENALTY_INIT, $urandom_range(0, 3) == 0 ? $urandom()
                                                              : $urandom_range(0, 4 * 65536));
    endtask

    task automatic run_random_phase(int n_items);
        int sent, seq_len, k;
        logic [22:0] lim;
        write_random_config();
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 19))
                0:       seq_len = $urandom_range(7, 30);
                1, 2:    seq_len = 1;
                default: seq_len = $urandom_range(2, 6);
            endcase
            for (k = 0; k < seq_len; k++) begin
                lim = $urandom_range(0, 1) ? lim_speed : lim_turn;
                send_control_step(1'($urandom_range(0, 1)), rand_ctrl(lim),
                                  rand_ctrl(lim_turn), rand_base(), k == seq_len - 1);
            end
            sent += seq_len;
        end
        wait_drained();
    endtask

    task automatic test_random();
        int ph;
        for (ph = 0; ph < 5; ph++) begin
            // one phase runs flat out on both sides
            tx_idle_en = (ph != 2);
            rx_idle_en = (ph != 2);
            run_random_phase(PHASE_ITEMS);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_register_extremes();
        test_penalty_ramp();
        test_backpressure();
        test_saturation();
        test_random();
        wait_drained();
        if (error_count == 0) begin
            $display("PASS augmented_lagrangian_penalty_unit");
        end else begin
            $display("FAIL augmented_lagrangian_penalty_unit");
        end
        $finish;
    end

endmodule
